FILE: rtl/core/assert_macros.svh
// assertion macros shared by the frustum cull rtl
// expects aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define AFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/afc_pkg.sv
// shared types and constants for the aabb frustum cull block
// no dependencies
package afc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PADDR_W     = 6;
    localparam int PDATA_W     = 64;
    localparam int REG_IDX_W   = 3;

    // verdict codes
    localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

    typedef logic [PDATA_W-1:0] plane_word_t;
    typedef plane_word_t [PLANE_COUNT-1:0] plane_arr_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } afc_adv_t;

endpackage

FILE: rtl/core/afc_cfg_regs.sv
// apb register file holding the six packed frustum planes
// depends on afc_pkg
module afc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afc_pkg::PADDR_W-1:0]   paddr,
    input  logic [afc_pkg::PDATA_W-1:0]   pwdata,
    output logic [afc_pkg::PDATA_W-1:0]   prdata,
    output afc_pkg::plane_arr_t           planes
);
    import afc_pkg::*;

    plane_arr_t             plane_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   idx_hit;

    // 64-bit registers at 8-byte spacing
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign idx_hit = (reg_idx < REG_IDX_W'(PLANE_COUNT));

    // register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (psel && penable && pwrite && idx_hit) begin
            plane_reg[reg_idx] <= pwdata;
        end
    end

    // read back, zero beyond the plane list
    always_comb begin
        prdata = '0;
        if (idx_hit) begin
            prdata = plane_reg[reg_idx];
        end
    end

    assign planes = plane_reg;

endmodule

FILE: rtl/core/afc_pipe_ctrl.sv
// valid tracking and stall control for the four-stage cull pipeline
// depends on afc_pkg and assert_macros.svh
module afc_pipe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output afc_pkg::afc_adv_t adv
);
    import afc_pkg::*;

    logic [3:0] v_reg;
    logic [3:0] v_next;
    logic [3:0] rdy;

    // a stage takes new data when empty or when its contents move on
    assign rdy[3] = !v_reg[3] || m_ready;
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];

    always_comb begin
        v_next = v_reg;
        if (rdy[0]) v_next[0] = s_valid;
        if (rdy[1]) v_next[1] = v_reg[0];
        if (rdy[2]) v_next[2] = v_reg[1];
        if (rdy[3]) v_next[3] = v_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign adv.ld1 = rdy[0];
    assign adv.ld2 = rdy[1];
    assign adv.ld3 = rdy[2];
    assign adv.ld4 = rdy[3];
    assign s_ready = rdy[0];
    assign m_valid = v_reg[3];

    // a held stage keeps its item
    `include "assert_macros.svh"
    `AFC_ASSERT_NEXT(a_hold_s1, v_reg[0] && !rdy[1], v_reg[0])
    `AFC_ASSERT_NEXT(a_hold_s3, v_reg[2] && !rdy[3], v_reg[2] && v_reg[3])
    // an accepted transfer lands in stage one
    `AFC_ASSERT_NEXT(a_take_s1, s_valid && s_ready, v_reg[0])

endmodule

FILE: rtl/core/afc_plane_lane.sv
// one plane lane: products, then s and e sums, then the two sign tests
// depends on afc_pkg
module afc_plane_lane (
    input  logic                 aclk,
    input  afc_pkg::afc_adv_t    adv,
    input  afc_pkg::plane_word_t plane,
    input  logic signed [15:0]   center_x,
    input  logic signed [15:0]   center_y,
    input  logic signed [15:0]   center_z,
    input  logic [14:0]          half_x,
    input  logic [14:0]          half_y,
    input  logic [14:0]          half_z,
    output logic                 is_out,
    output logic                 is_cross
);
    import afc_pkg::*;

    logic signed [15:0] nx, ny, nz, dd;
    logic [15:0]        ax, ay, az;
    logic [30:0]        ex_full, ey_full, ez_full;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [29:0]        qx_reg, qy_reg, qz_reg;
    logic signed [15:0] d_reg;

    logic signed [32:0] s_next, s_reg;
    logic [31:0]        e_next, e_reg;

    logic signed [33:0] sum_pe, sum_me;
    logic               out_reg, cross_reg;

    // unpack the plane
    assign nx = plane[15:0];
    assign ny = plane[31:16];
    assign nz = plane[47:32];
    assign dd = plane[63:48];

    // magnitude of each normal, 0x8000 stays 32768
    assign ax = nx[15] ? (~nx + 16'd1) : nx;
    assign ay = ny[15] ? (~ny + 16'd1) : ny;
    assign az = nz[15] ? (~nz + 16'd1) : nz;

    assign ex_full = 31'(half_x) * 31'(ax);
    assign ey_full = 31'(half_y) * 31'(ay);
    assign ez_full = 31'(half_z) * 31'(az);

    // stage 1: exact products
    always_ff @(posedge aclk) begin
        if (adv.ld1) begin
            px_reg <= 32'(center_x) * 32'(nx);
            py_reg <= 32'(center_y) * 32'(ny);
            pz_reg <= 32'(center_z) * 32'(nz);
            qx_reg <= ex_full[29:0];
            qy_reg <= ey_full[29:0];
            qz_reg <= ez_full[29:0];
            d_reg  <= dd;
        end
    end

    // stage 2: signed distance and projected radius, d scaled to 2^18
    assign s_next = 33'(px_reg) + 33'(py_reg) + 33'(pz_reg)
                  + $signed({{3{d_reg[15]}}, d_reg, 14'b0});
    assign e_next = 32'(qx_reg) + 32'(qy_reg) + 32'(qz_reg);

    always_ff @(posedge aclk) begin
        if (adv.ld2) begin
            s_reg <= s_next;
            e_reg <= e_next;
        end
    end

    // stage 3: s+e below zero, s-e at or below zero
    assign sum_pe = 34'(s_reg) + $signed({2'b00, e_reg});
    assign sum_me = 34'(s_reg) - $signed({2'b00, e_reg});

    always_ff @(posedge aclk) begin
        if (adv.ld3) begin
            out_reg   <= sum_pe[33];
            cross_reg <= sum_me[33] || (sum_me == '0);
        end
    end

    assign is_out   = out_reg;
    assign is_cross = cross_reg;

endmodule

FILE: rtl/core/aabb_frustum_cull_top.sv
// top level of the aabb frustum cull block: six plane lanes and the verdict stage
// depends on afc_pkg, afc_cfg_regs, afc_pipe_ctrl, afc_plane_lane, assert_macros.svh
//
//   channel   ports                       carries
//   s_        s_valid/s_ready + 6 fields  box center and half extents
//   m_        m_valid/m_ready + verdict   0 inside, 1 intersecting, 2 outside
//   apb       psel..prdata, 64-bit data   plane_0..plane_5 at 8*i
//
// one box per cycle through four register stages while the output is not stalled
// stages: products, s and e sums, sign tests in six parallel lanes, then verdict
// a stalled output holds its stage; earlier stages keep filling their bubbles
// reset clears the valid bits and all planes to zero (every box then intersects)
module aabb_frustum_cull_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_center_x,
    input  logic signed [15:0]          s_center_y,
    input  logic signed [15:0]          s_center_z,
    input  logic [14:0]                 s_half_x,
    input  logic [14:0]                 s_half_y,
    input  logic [14:0]                 s_half_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_verdict,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [afc_pkg::PADDR_W-1:0] paddr,
    input  logic [afc_pkg::PDATA_W-1:0] pwdata,
    output logic [afc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import afc_pkg::*;

    plane_arr_t             planes;
    afc_adv_t               adv;
    logic [PLANE_COUNT-1:0] lane_out;
    logic [PLANE_COUNT-1:0] lane_cross;
    logic [1:0]             verdict_next, verdict_reg;

    assign pready = 1'b1;

    // plane registers
    afc_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .planes  (planes)
    );

    // valid and stall control
    afc_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .adv     (adv)
    );

    // one lane per plane
    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
        afc_plane_lane u_lane (
            .aclk     (aclk),
            .adv      (adv),
            .plane    (planes[i]),
            .center_x (s_center_x),
            .center_y (s_center_y),
            .center_z (s_center_z),
            .half_x   (s_half_x),
            .half_y   (s_half_y),
            .half_z   (s_half_z),
            .is_out   (lane_out[i]),
            .is_cross (lane_cross[i])
        );
    end

    // stage 4: combine the lanes, outside wins over intersecting
    always_comb begin
        if (|lane_out) begin
            verdict_next = VERDICT_OUTSIDE;
        end else if (|lane_cross) begin
            verdict_next = VERDICT_INTERSECT;
        end else begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.ld4) begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_verdict = verdict_reg;

    // a delivered verdict is always one of the three codes
    `include "assert_macros.svh"
    `AFC_ASSERT_NOW(a_verdict_code, m_valid, m_verdict <= VERDICT_OUTSIDE)

endmodule

FILE: dv/aabb_frustum_cull_tb.sv
// testbench for aabb_frustum_cull_top: six-plane box culling with apb plane registers
// depends on afc_pkg and the rtl under rtl/core; a built-in classifier predicts each verdict
// stimulus: directed corner boxes, then randomized frusta with random stalls on both sides
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int AW = afc_pkg::PADDR_W;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic [14:0]        hx;
        logic [14:0]        hy;
        logic [14:0]        hz;
    } box_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [15:0]   s_center_x;
    logic signed [15:0]   s_center_y;
    logic signed [15:0]   s_center_z;
    logic [14:0]          s_half_x;
    logic [14:0]          s_half_y;
    logic [14:0]          s_half_z;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_verdict;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AW-1:0]        paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // shadow of the plane registers and verdicts still in flight
    logic [63:0]          plane_shadow [PLANE_COUNT];
    logic [1:0]           expected_verdicts [$];

    int                   error_count;
    int                   boxes_accepted;
    int                   settings_count;
    int                   seen_inside;
    int                   seen_intersect;
    int                   seen_outside;
    int                   sink_hold;
    bit                   src_steady;
    bit                   sink_steady;

    aabb_frustum_cull_top i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_center_z (s_center_z),
        .s_half_x   (s_half_x),
        .s_half_y   (s_half_y),
        .s_half_z   (s_half_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_verdict  (m_verdict),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    // classify one box against the shadow planes, exact integer math
    function automatic logic [1:0] classify_box(input logic signed [15:0] cx,
                                                input logic signed [15:0] cy,
                                                input logic signed [15:0] cz,
                                                input logic [14:0] hx,
                                                input logic [14:0] hy,
                                                input logic [14:0] hz);
        longint nx, ny, nz, dd, radius, plane_dist;
        bit any_out, any_cross;
        any_out = 1'b0;
        any_cross = 1'b0;
        for (int k = 0; k < PLANE_COUNT; k++) begin
            nx = $signed(plane_shadow[k][15:0]);
            ny = $signed(plane_shadow[k][31:16]);
            nz = $signed(plane_shadow[k][47:32]);
            dd = $signed(plane_shadow[k][63:48]);
            radius = longint'(hx) * (nx < 0 ? -nx : nx)
                   + longint'(hy) * (ny < 0 ? -ny : ny)
                   + longint'(hz) * (nz < 0 ? -nz : nz);
            // d is Q12.4, bring it to the Q.18 scale of the products
            plane_dist = longint'(cx) * nx + longint'(cy) * ny + longint'(cz) * nz
                       + dd * 16384;
            if (plane_dist + radius < 0) any_out = 1'b1;
            if (plane_dist - radius <= 0) any_cross = 1'b1;
        end
        if (any_out) return VERDICT_OUTSIDE;
        if (any_cross) return VERDICT_INTERSECT;
        return VERDICT_INSIDE;
    endfunction

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // input and output monitors: predict on input transfer, check on output transfer
    always @(posedge aclk) begin
        logic [1:0] want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_verdicts.push_back(classify_box(s_center_x, s_center_y, s_center_z,
                                                         s_half_x, s_half_y, s_half_z));
                boxes_accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict %0d with no box pending", m_verdict));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_verdict !== want)
                        report_mismatch($sformatf("verdict %0d, predicted %0d",
                                                  m_verdict, want));
                    case (m_verdict)
                        VERDICT_INSIDE:    seen_inside++;
                        VERDICT_INTERSECT: seen_intersect++;
                        VERDICT_OUTSIDE:   seen_outside++;
                        default: ;
                    endcase
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        sink_hold = 0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_ready = 1'b0;
                sink_hold--;
            end else begin
                m_ready = 1'b1;
                sink_hold = pick_gap(sink_steady);
            end
        end
    end

    // one box transfer, with an optional gap before it
    task automatic send_box(input box_t b);
        int gap;
        gap = pick_gap(src_steady);
        @(negedge aclk);
        repeat (gap) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_center_x = b.cx;
        s_center_y = b.cy;
        s_center_z = b.cz;
        s_half_x   = b.hx;
        s_half_y   = b.hy;
        s_half_z   = b.hz;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic apb_write(input int unsigned idx, input logic [63:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = AW'(idx << 3);
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx < PLANE_COUNT) plane_shadow[idx] = value;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic box_t mk_box(input int cx, input int cy, input int cz,
                                    input int hx, input int hy, input int hz);
        box_t b;
        b.cx = 16'(cx);
        b.cy = 16'(cy);
        b.cz = 16'(cz);
        b.hx = 15'(hx);
        b.hy = 15'(hy);
        b.hz = 15'(hz);
        return b;
    endfunction

    function automatic logic [63:0] pack_plane(input int nx, input int ny, input int nz,
                                               input int dd);
        return {16'(dd), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    // near boxes sit around the frustum, others use every bit
    function automatic box_t random_box(input bit near, input int span);
        box_t b;
        if (!near) begin
            b.cx = 16'($urandom);
            b.cy = 16'($urandom);
            b.cz = 16'($urandom);
            b.hx = 15'($urandom);
            b.hy = 15'($urandom);
            b.hz = 15'($urandom);
        end else begin
            b = mk_box(int'($urandom_range(0, 2 * span)) - span,
                       int'($urandom_range(0, 2 * span)) - span,
                       int'($urandom_range(0, 2 * span)) - span,
                       $urandom_range(0, span / 2),
                       $urandom_range(0, span / 2),
                       $urandom_range(0, span / 2));
        end
        return b;
    endfunction

    // one face of a slightly tilted box frustum, plane k faces axis k/2
    function automatic logic [63:0] frustum_plane(input int k, input int reach);
        int n [3];
        for (int j = 0; j < 3; j++) n[j] = int'($urandom_range(0, 4096)) - 2048;
        n[k / 2] = $urandom_range(8192, 16384);
        if (k % 2) n[k / 2] = -n[k / 2];
        return pack_plane(n[0], n[1], n[2], reach);
    endfunction

    // after reset every plane is zero, so every box intersects
    task automatic test_reset_planes();
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, 0, 0, 0));
        send_box(mk_box(-32768, 32767, 0, 32767, 0, 32767));
        send_box(mk_box(100, -100, 5, 1, 2, 3));
        wait_idle();
    endtask

    // axis-aligned cube of half size 100.0, with touching cases on both sides
    task automatic test_axis_cube();
        for (int k = 0; k < PLANE_COUNT; k++)
            apb_write(k, pack_plane(k / 2 == 0 ? (k % 2 ? -16384 : 16384) : 0,
                                    k / 2 == 1 ? (k % 2 ? -16384 : 16384) : 0,
                                    k / 2 == 2 ? (k % 2 ? -16384 : 16384) : 0, 1600));
        settings_count++;
        send_box(mk_box(0, 0, 0, 100, 100, 100));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        // box face lies on a plane from inside
        send_box(mk_box(1500, 0, 0, 100, 0, 0));
        // box face lies on a plane from outside
        send_box(mk_box(-1700, 0, 0, 100, 0, 0));
        send_box(mk_box(-1701, 0, 0, 100, 0, 0));
        send_box(mk_box(0, 0, 2000, 50, 50, 50));
        send_box(mk_box(0, 0, 0, 32767, 32767, 32767));
        send_box(mk_box(32767, -32768, 0, 0, 0, 0));
        wait_idle();
    endtask

    // writes past the last plane leave the planes as they were
    task automatic test_ignored_index();
        apb_write(PLANE_COUNT, '1);
        apb_write(PLANE_COUNT + 1, 64'h8000_8000_8000_8000);
        send_box(mk_box(0, 0, 0, 10, 10, 10));
        send_box(mk_box(1590, -1590, 0, 10, 10, 0));
        send_box(mk_box(0, 0, -3000, 5, 5, 5));
        wait_idle();
    endtask

    // most negative normals and extreme d against extreme boxes
    task automatic test_extreme_planes();
        apb_write(0, pack_plane(-32768, -32768, -32768, 32767));
        apb_write(1, pack_plane(32767, 32767, 32767, -32768));
        apb_write(2, pack_plane(0, -32768, 32767, 32767));
        apb_write(3, pack_plane(-32768, 32767, -32768, -32768));
        apb_write(4, pack_plane(-32768, 0, 0, 32767));
        apb_write(5, pack_plane(0, -32768, 0, 32767));
        settings_count++;
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(-32768, 32767, -32768, 0, 0, 0));
        send_box(mk_box(32767, -32768, 32767, 32767, 0, 32767));
        send_box(mk_box(-1, -1, -1, 1, 1, 1));
        wait_idle();
    endtask

    // randomized frusta, each setting followed by a burst of boxes
    task automatic test_random_frusta();
        int style, reach, span, zero_idx;
        for (int phase = 0; phase < 12; phase++) begin
            style = phase % 4;
            src_steady  = (phase % 5 == 4);
            sink_steady = (phase % 5 == 4);
            reach = $urandom_range(200, 4000);
            span  = reach * 3 / 2 + 600;
            zero_idx = $urandom_range(0, PLANE_COUNT - 1);
            for (int k = 0; k < PLANE_COUNT; k++) begin
                if (style == 2)
                    apb_write(k, {$urandom, $urandom});
                else if (style == 3 && k == zero_idx)
                    apb_write(k, '0);
                else
                    apb_write(k, frustum_plane(k, reach));
            end
            settings_count++;
            for (int n = 0; n < 100; n++)
                send_box(random_box(style != 2 && $urandom_range(0, 99) < 85, span));
            wait_idle();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // main sequence
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_center_x  = '0;
        s_center_y  = '0;
        s_center_z  = '0;
        s_half_x    = '0;
        s_half_y    = '0;
        s_half_z    = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        error_count = 0;
        boxes_accepted = 0;
        settings_count = 1;
        seen_inside    = 0;
        seen_intersect = 0;
        seen_outside   = 0;
        for (int k = 0; k < PLANE_COUNT; k++) plane_shadow[k] = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_planes();
        test_axis_cube();
        test_ignored_index();
        test_extreme_planes();
        test_random_frusta();

        wait_idle();
        $display("covered %0d boxes over %0d plane settings", boxes_accepted, settings_count);
        $display("verdicts: %0d inside, %0d intersecting, %0d outside",
                 seen_inside, seen_intersect, seen_outside);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/afc_pkg.sv
rtl/core/afc_cfg_regs.sv
rtl/core/afc_pipe_ctrl.sv
rtl/core/afc_plane_lane.sv
rtl/core/aabb_frustum_cull_top.sv
dv/aabb_frustum_cull_tb.sv
